// ===== sv/olst_pkg.sv =====
package olst_pkg;

  localparam int CAPACITY  = 16;
  localparam int ELEM_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int POS_W     = 4;
  localparam int VAL_W     = 32;
  localparam int CNTO_W    = 5;
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_FIRST  = 3'd3,
    OP_LAST   = 3'd4,
    OP_GET    = 3'd5,
    OP_SET    = 3'd6,
    OP_CLEAR  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef logic [ELEM_BITS-1:0] elem_t;

  typedef struct packed {
    op_t                     operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } in_word_t;

  typedef struct packed {
    status_t                 status;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] read_value;
    logic [CNTO_W-1:0]       count_after;
  } out_word_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] pos;
    elem_t            val;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] fpos;
    elem_t            rd;
    logic [CNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    elem_t            wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  function automatic elem_t to_elem(logic signed [VAL_W-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[ELEM_BITS-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] elem_out(elem_t e);
    logic [63:0] z;
    z = 64'(e);
    return z[VAL_W-1:0];
  endfunction

endpackage

// ===== sv/ordered_list_engine_top.sv =====
// From accept to result strobe, append, set, clear and rejected operations pass the
// command register and the result register; get also waits for the registered RAM read;
// searches, insert and remove walk the list, as the single read port of the entry RAM
// walks one entry per cycle. One word is in flight at a time and busy is high meanwhile;
// the next word is taken at the edge that takes the result. The receiver cannot stall.
// Synchronous reset empties the list; the stored entries are not cleared.
module ordered_list_engine_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  olst_pkg::in_word_t  in_word,
  output logic                out_valid,
  output olst_pkg::out_word_t out_word
);

  import olst_pkg::*;

  cmd_t      cmd_r;
  logic      go_r;
  ram_req_t  ram_req;
  elem_t     rdata;
  res_t      res;
  seq_stat_t stat;
  logic      accept;

  assign accept = start && !busy;
  assign busy   = go_r || stat.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
    end else begin
      go_r <= accept;
    end
    if (accept) begin
      cmd_r.op  <= in_word.operation;
      cmd_r.pos <= in_word.position;
      cmd_r.val <= to_elem(in_word.item_value);
    end
  end

  olst_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  olst_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go_r),
    .cmd     (cmd_r),
    .rdata   (rdata),
    .ram_req (ram_req),
    .res     (res),
    .stat    (stat)
  );

  assign out_valid               = stat.done;
  assign out_word.status         = res.status;
  assign out_word.found_position = POS_W'(res.fpos);
  assign out_word.read_value     = elem_out(res.rd);
  assign out_word.count_after    = CNTO_W'(res.count);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy did not rise after an accepted word");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result appeared without a word in flight");

endmodule

// ===== sv/olst_ram.sv =====
module olst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/olst_seq.sv =====
module olst_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  olst_pkg::cmd_t     cmd,
  input  olst_pkg::elem_t    rdata,
  output olst_pkg::ram_req_t ram_req,
  output olst_pkg::res_t     res,
  output olst_pkg::seq_stat_t stat
);

  import olst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRV,
    S_GETW
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             pend_r, pend_nxt;
  logic             up_r, up_nxt;
  logic [IDX_W-1:0] fpos_r, fpos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  res_t             res_r, res_nxt;
  logic             done_r, done_nxt;

  logic             pos_ok;
  logic             full;
  logic             hit;
  logic             issue;
  logic [CNT_W-1:0] last_ext;

  assign pos_ok   = CMP_W'(cmd.pos) < CMP_W'(cnt_r);
  assign full     = cnt_r >= CNT_W'(CAPACITY);
  assign hit      = pend_r && (rdata == cmd.val);
  assign issue    = rem_r != '0;
  assign last_ext = CNT_W'(last_r);

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    last_nxt  = last_r;
    rem_nxt   = rem_r;
    pend_nxt  = 1'b0;
    up_nxt    = up_r;
    fpos_nxt  = fpos_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;

    ram_req.we    = 1'b0;
    ram_req.waddr = last_r;
    ram_req.wdata = rdata;
    ram_req.raddr = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (go) begin
          res_nxt.status = ST_OK;
          res_nxt.fpos   = '0;
          res_nxt.rd     = '0;
          res_nxt.count  = cnt_r;
          case (cmd.op)
            OP_APPEND: begin
              done_nxt = 1'b1;
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cnt_r[IDX_W-1:0];
                ram_req.wdata = cmd.val;
                cnt_nxt       = cnt_r + CNT_W'(1);
                res_nxt.count = cnt_r + CNT_W'(1);
              end
            end
            OP_INSERT: begin
              if (!pos_ok) begin
                res_nxt.status = ST_RANGE;
                done_nxt       = 1'b1;
              end else if (full) begin
                res_nxt.status = ST_FULL;
                done_nxt       = 1'b1;
              end else begin
                ptr_nxt   = IDX_W'(cnt_r - CNT_W'(1));
                rem_nxt   = cnt_r - CNT_W'(cmd.pos);
                up_nxt    = 1'b1;
                state_nxt = S_SHIFT;
              end
            end
            OP_REMOVE, OP_FIRST, OP_LAST: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_NOTFOUND;
                res_nxt.rd     = (cmd.op == OP_REMOVE) ? cmd.val : '0;
                done_nxt       = 1'b1;
              end else begin
                ptr_nxt   = (cmd.op == OP_LAST) ? IDX_W'(cnt_r - CNT_W'(1)) : '0;
                rem_nxt   = cnt_r;
                state_nxt = S_SCAN;
              end
            end
            OP_GET: begin
              if (!pos_ok) begin
                res_nxt.status = ST_RANGE;
                done_nxt       = 1'b1;
              end else begin
                ram_req.raddr = IDX_W'(cmd.pos);
                state_nxt     = S_GETW;
              end
            end
            OP_SET: begin
              done_nxt = 1'b1;
              if (!pos_ok) begin
                res_nxt.status = ST_RANGE;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = IDX_W'(cmd.pos);
                ram_req.wdata = cmd.val;
                res_nxt.rd    = cmd.val;
              end
            end
            OP_CLEAR: begin
              cnt_nxt       = '0;
              res_nxt.count = '0;
              done_nxt      = 1'b1;
            end
            default: begin
              done_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue) begin
          last_nxt = ptr_r;
          ptr_nxt  = (cmd.op == OP_LAST) ? ptr_r - IDX_W'(1) : ptr_r + IDX_W'(1);
          rem_nxt  = rem_r - CNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (hit) begin
          if (cmd.op == OP_REMOVE && (last_ext + CNT_W'(1) < cnt_r)) begin
            ptr_nxt   = last_r + IDX_W'(1);
            rem_nxt   = cnt_r - last_ext - CNT_W'(1);
            pend_nxt  = 1'b0;
            up_nxt    = 1'b0;
            fpos_nxt  = last_r;
            state_nxt = S_SHIFT;
          end else begin
            res_nxt.status = ST_OK;
            res_nxt.fpos   = last_r;
            res_nxt.rd     = cmd.val;
            if (cmd.op == OP_REMOVE) begin
              cnt_nxt       = cnt_r - CNT_W'(1);
              res_nxt.count = cnt_r - CNT_W'(1);
            end
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (pend_r && !issue) begin
          res_nxt.status = ST_NOTFOUND;
          res_nxt.rd     = (cmd.op == OP_REMOVE) ? cmd.val : '0;
          done_nxt       = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_SHIFT: begin
        if (issue) begin
          last_nxt = ptr_r;
          ptr_nxt  = up_r ? ptr_r - IDX_W'(1) : ptr_r + IDX_W'(1);
          rem_nxt  = rem_r - CNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = up_r ? last_r + IDX_W'(1) : last_r - IDX_W'(1);
          ram_req.wdata = rdata;
          if (!issue) begin
            if (up_r) begin
              state_nxt = S_WRV;
            end else begin
              cnt_nxt        = cnt_r - CNT_W'(1);
              res_nxt.status = ST_OK;
              res_nxt.fpos   = fpos_r;
              res_nxt.rd     = cmd.val;
              res_nxt.count  = cnt_r - CNT_W'(1);
              done_nxt       = 1'b1;
              state_nxt      = S_IDLE;
            end
          end
        end
      end

      S_WRV: begin
        ram_req.we     = 1'b1;
        ram_req.waddr  = IDX_W'(cmd.pos);
        ram_req.wdata  = cmd.val;
        cnt_nxt        = cnt_r + CNT_W'(1);
        res_nxt.status = ST_OK;
        res_nxt.count  = cnt_r + CNT_W'(1);
        done_nxt       = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_GETW: begin
        res_nxt.rd = rdata;
        done_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      rem_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      rem_r   <= rem_nxt;
      done_r  <= done_nxt;
    end
    ptr_r  <= ptr_nxt;
    last_r <= last_nxt;
    up_r   <= up_nxt;
    fpos_r <= fpos_nxt;
    res_r  <= res_nxt;
  end

  assign res       = res_r;
  assign stat.busy = state_r != S_IDLE;
  assign stat.done = done_r;

endmodule

// ===== tb/sv/ordered_list_engine_top_tb.sv =====
module ordered_list_engine_top_tb;
  import olst_pkg::*;

  localparam int RANDOM_WORDS   = 1620;
  localparam int STALL_LIMIT    = 3000;
  localparam int SETTLE_CYCLES  = 24;

  typedef struct {
    op_t              op;
    logic [3:0]       pos;
    logic [31:0]      val;
    int               reps;
    bit               typed;
    out_word_t        want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  logic [31:0] shadow_entries [CAPACITY];
  int          shadow_len;
  out_word_t   pending_results[$];
  dir_row_t    dir_rows[$];
  int          idle_pct;
  int          words_sent;
  int          dir_words;
  int          results_checked;
  int          mismatches;
  int          stall_cycles;
  int          status_seen[4];
  logic [31:0] value_pool[6];

  ordered_list_engine_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always #4 clk = ~clk;

  function automatic out_word_t list_apply(in_word_t w);
    out_word_t r;
    int        i;
    int        hit_at;
    r = '0;
    r.status = ST_OK;
    hit_at = -1;
    case (w.operation)
      OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_len] = w.item_value;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        if (int'(w.position) >= shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > int'(w.position); i--)
            shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[w.position] = w.item_value;
          shadow_len++;
        end
      end
      OP_REMOVE, OP_FIRST: begin
        for (i = 0; i < shadow_len && hit_at < 0; i++)
          if (shadow_entries[i] == w.item_value) hit_at = i;
        if (hit_at < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found_position = hit_at[3:0];
        end
        if (w.operation == OP_REMOVE) begin
          r.read_value = w.item_value;
          if (hit_at >= 0) begin
            for (i = hit_at; i + 1 < shadow_len; i++)
              shadow_entries[i] = shadow_entries[i+1];
            shadow_len--;
          end
        end else if (hit_at >= 0) begin
          r.read_value = w.item_value;
        end
      end
      OP_LAST: begin
        for (i = shadow_len - 1; i >= 0 && hit_at < 0; i--)
          if (shadow_entries[i] == w.item_value) hit_at = i;
        if (hit_at < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found_position = hit_at[3:0];
          r.read_value = w.item_value;
        end
      end
      OP_GET: begin
        if (int'(w.position) >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = shadow_entries[w.position];
        end
      end
      OP_SET: begin
        if (int'(w.position) >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          shadow_entries[w.position] = w.item_value;
          r.read_value = w.item_value;
        end
      end
      default: begin
        shadow_len = 0;
      end
    endcase
    r.count_after = 5'(shadow_len);
    return r;
  endfunction

  function automatic void add_row(op_t op, int pos, logic [31:0] val, int reps, bit typed,
                                  status_t st, int fpos, logic [31:0] rd, int cnt);
    dir_row_t row;
    row.op = op;
    row.pos = pos[3:0];
    row.val = val;
    row.reps = reps;
    row.typed = typed;
    row.want.status = st;
    row.want.found_position = fpos[3:0];
    row.want.read_value = rd;
    row.want.count_after = cnt[4:0];
    dir_rows.push_back(row);
  endfunction

  function automatic void add_step(op_t op, int pos, logic [31:0] val, int reps);
    add_row(op, pos, val, reps, 1'b0, ST_OK, 0, '0, 0);
  endfunction

  function automatic void add_check(op_t op, int pos, logic [31:0] val,
                                    status_t st, int fpos, logic [31:0] rd, int cnt);
    add_row(op, pos, val, 1, 1'b1, st, fpos, rd, cnt);
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       k;
    k = $urandom_range(0, 99);
    if (k < 30)      w.operation = OP_APPEND;
    else if (k < 44) w.operation = OP_INSERT;
    else if (k < 58) w.operation = OP_REMOVE;
    else if (k < 68) w.operation = OP_FIRST;
    else if (k < 78) w.operation = OP_LAST;
    else if (k < 88) w.operation = OP_GET;
    else if (k < 97) w.operation = OP_SET;
    else             w.operation = OP_CLEAR;
    if (shadow_len > 0 && $urandom_range(0, 99) < 80) begin
      w.position = 4'($urandom_range(0, shadow_len - 1));
    end else begin
      w.position = 4'($urandom_range(0, 15));
    end
    k = $urandom_range(0, 99);
    if (k < 65) begin
      w.item_value = value_pool[$urandom_range(0, 5)];
    end else if (k < 85 && shadow_len > 0) begin
      w.item_value = shadow_entries[$urandom_range(0, shadow_len - 1)];
    end else begin
      w.item_value = $urandom;
    end
    return w;
  endfunction

  task automatic drive_word(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t pred;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = list_apply(w);
    pending_results.push_back(typed ? want : pred);
    words_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      results_checked++;
      status_seen[out_word.status]++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: %p", out_word);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          mismatches++;
        end
        if (out_word.found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 want.found_position, out_word.found_position);
          mismatches++;
        end
        if (out_word.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_word.read_value);
          mismatches++;
        end
        if (out_word.count_after !== want.count_after) begin
          $error("count_after: expected %0d, got %0d", want.count_after, out_word.count_after);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    in_word_t  w;
    out_word_t none;
    int        n;
    int        r;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    none = '0;
    shadow_len = 0;
    idle_pct = 32;
    words_sent = 0;
    results_checked = 0;
    mismatches = 0;
    stall_cycles = 0;
    for (n = 0; n < 4; n++) status_seen[n] = 0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'h0000_0001;
    value_pool[2] = 32'hFFFF_FFFF;
    value_pool[3] = 32'h0000_0007;
    value_pool[4] = 32'h8000_0000;
    value_pool[5] = 32'h7FFF_FFFF;

    add_check(OP_GET,    0, 32'd0,         ST_RANGE,    0, 32'd0,         0);
    add_check(OP_FIRST,  0, 32'd5,         ST_NOTFOUND, 0, 32'd0,         0);
    add_check(OP_REMOVE, 0, 32'd7,         ST_NOTFOUND, 0, 32'd7,         0);
    add_check(OP_INSERT, 0, 32'd1,         ST_RANGE,    0, 32'd0,         0);
    add_check(OP_APPEND, 0, 32'h8000_0000, ST_OK,       0, 32'd0,         1);
    add_check(OP_APPEND, 15, 32'h7FFF_FFFF, ST_OK,      0, 32'd0,         2);
    add_step(OP_INSERT,  1, 32'hFFFF_FFFF, 1);
    add_check(OP_INSERT, 3, 32'd0,         ST_RANGE,    0, 32'd0,         3);
    add_step(OP_GET,     1, 32'd0, 1);
    add_step(OP_APPEND,  0, 32'd0, 13);
    add_check(OP_APPEND, 0, 32'd9,         ST_FULL,     0, 32'd0,         16);
    add_check(OP_INSERT, 15, 32'd9,        ST_FULL,     0, 32'd0,         16);
    add_step(OP_GET,     15, 32'd0, 1);
    add_step(OP_FIRST,   0, 32'hFFFF_FFFF, 1);
    add_step(OP_LAST,    0, 32'hFFFF_FFFF, 1);
    add_step(OP_SET,     0, 32'h5A5A_5A5A, 1);
    add_step(OP_GET,     0, 32'd0, 1);
    add_step(OP_REMOVE,  0, 32'hFFFF_FFFF, 1);
    add_check(OP_INSERT, 15, 32'd0,        ST_RANGE,    0, 32'd0,         15);
    add_check(OP_GET,    15, 32'd0,        ST_RANGE,    0, 32'd0,         15);
    add_check(OP_SET,    15, 32'd3,        ST_RANGE,    0, 32'd0,         15);
    add_step(OP_LAST,    0, 32'h1234_5678, 1);
    add_check(OP_CLEAR,  0, 32'd0,         ST_OK,       0, 32'd0,         0);
    add_check(OP_GET,    0, 32'd0,         ST_RANGE,    0, 32'd0,         0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      for (r = 0; r < dir_rows[i].reps; r++) begin
        w.operation = dir_rows[i].op;
        w.position = dir_rows[i].pos;
        w.item_value = (dir_rows[i].reps > 1) ?
                       32'($urandom_range(0, 3)) - 32'd1 : dir_rows[i].val;
        drive_word(w, dir_rows[i].typed, dir_rows[i].want);
      end
    end
    dir_words = words_sent;
    drain_results();

    for (n = 0; n < RANDOM_WORDS; n++) begin
      idle_pct = (n >= 500 && n < 900) ? 0 : 32;
      if (n == 800) drain_results();
      w = random_word();
      drive_word(w, 1'b0, none);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d directed, rest random over all operations), checked %0d.",
             words_sent, dir_words, results_checked);
    $display("Statuses seen: ok %0d, out of range %0d, not found %0d, full %0d.",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_NOTFOUND],
             status_seen[ST_FULL]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/olst_pkg.sv
sv/olst_ram.sv
sv/olst_seq.sv
sv/ordered_list_engine_top.sv
tb/sv/ordered_list_engine_top_tb.sv
